@@ hw/rtl/kls_pkg.sv @@
// Shared types and constants for the k-th largest stream selector.
package kls_pkg;

	localparam int DATA_W    = 32;
	localparam int RANK_W    = 5;
	localparam int MAX_K_DEF = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PLACE,
		ST_FIN,
		ST_RESULT
	} state_t;

endpackage

@@ hw/rtl/kls_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module kls_ram #(
	parameter int WIDTH = kls_pkg::DATA_W,
	parameter int DEPTH = kls_pkg::MAX_K_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/kth_largest_stream_select.sv @@
// Top level: streaming k-th largest selector over a sorted value RAM.
// Per item: accept, one RAM read-and-shift per kept entry smaller than the new value,
// then the value drops into the hole (PLACE at top); an empty store writes it on accept.
// A last item then passes FIN and RESULT (result read) before its result is offered.
// Throughput: one item at a time; the insertion walk over the RAM sets the rate.
// Reset (arst_n low): empty store, rank 1, no result pending; RAM is not cleared.
module kth_largest_stream_select #(
	parameter int MAX_K = kls_pkg::MAX_K_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration: rank to report
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [kls_pkg::RANK_W-1:0]        rank_k,
	// input items
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [kls_pkg::DATA_W-1:0] value,
	input  logic                              last,
	// results
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [kls_pkg::DATA_W-1:0] kth_value,
	output logic                              short_set
);

	// count width holds 0..MAX_K; address width indexes 0..MAX_K-1
	localparam int CW = $clog2(MAX_K + 1);
	localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int EW = (CW > kls_pkg::RANK_W) ? CW : kls_pkg::RANK_W;

	// The RAM holds the kept values sorted largest first in entries 0..cnt-1.
	// Insertion walks a hole up from the bottom: each entry smaller than the new
	// value moves down one slot, then the value drops into the hole. Entries at
	// or beyond k are never written, so dropping the smallest is free.
	kls_pkg::state_t state_q, state_d;

	logic [kls_pkg::RANK_W-1:0]        rank_q;
	logic [CW-1:0]                     cnt_q, cnt_d;
	logic [CW-1:0]                     k_q;
	logic [CW-1:0]                     h_q, h_d;
	logic signed [kls_pkg::DATA_W-1:0] val_q;
	logic                              last_q;
	logic                              short_q;

	logic                              out_valid_q;
	logic signed [kls_pkg::DATA_W-1:0] kth_q;
	logic                              short_out_q;

	logic [EW-1:0]                     rank_ext;
	logic [CW-1:0]                     keff;
	logic [CW-1:0]                     cnt_new;
	logic [CW-1:0]                     h0;

	logic                              ram_we;
	logic [CW-1:0]                     wr_idx;
	logic [CW-1:0]                     rd_idx;
	logic [kls_pkg::DATA_W-1:0]        ram_wdata;
	logic [kls_pkg::DATA_W-1:0]        ram_rdata;
	logic                              load_out;
	logic                              accept;

	// rank 0 acts as 1, ranks above the store saturate
	always_comb begin
		rank_ext = EW'(rank_q);
		if (rank_ext == '0) begin
			keff = CW'(1);
		end else if (rank_ext > EW'(MAX_K)) begin
			keff = CW'(MAX_K);
		end else begin
			keff = CW'(rank_ext);
		end
	end

	// store grows until k; once at k the walk starts at slot k (discarded)
	assign cnt_new = (cnt_q < keff) ? (cnt_q + CW'(1)) : keff;
	assign h0      = (cnt_q < keff) ? cnt_q : keff;
	assign accept  = in_valid && in_ready;

	always_comb begin
		state_d   = state_q;
		h_d       = h_q;
		cnt_d     = cnt_q;
		ram_we    = 1'b0;
		wr_idx    = h_q;
		ram_wdata = val_q;
		rd_idx    = h_q - CW'(1);
		load_out  = 1'b0;
		in_ready  = 1'b0;
		unique case (state_q)
			kls_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cnt_d = cnt_new;
					h_d   = h0;
					if (h0 == '0) begin
						// empty store: value goes straight to the top
						ram_we    = 1'b1;
						wr_idx    = '0;
						ram_wdata = value;
						state_d   = last ? kls_pkg::ST_FIN : kls_pkg::ST_IDLE;
					end else begin
						rd_idx  = h0 - CW'(1);
						state_d = kls_pkg::ST_SCAN;
					end
				end
			end
			kls_pkg::ST_SCAN: begin
				// ram_rdata is entry h_q-1
				ram_we = (h_q < k_q);
				wr_idx = h_q;
				if ($signed(ram_rdata) < val_q) begin
					ram_wdata = ram_rdata;
					h_d       = h_q - CW'(1);
					if (h_q == CW'(1)) begin
						state_d = kls_pkg::ST_PLACE;
					end else begin
						rd_idx = h_q - CW'(2);
					end
				end else begin
					ram_wdata = val_q;
					state_d   = last_q ? kls_pkg::ST_FIN : kls_pkg::ST_IDLE;
				end
			end
			kls_pkg::ST_PLACE: begin
				ram_we    = 1'b1;
				ram_wdata = val_q;
				state_d   = last_q ? kls_pkg::ST_FIN : kls_pkg::ST_IDLE;
			end
			kls_pkg::ST_FIN: begin
				// smallest kept value sits at the bottom of the sorted store
				rd_idx  = cnt_q - CW'(1);
				state_d = kls_pkg::ST_RESULT;
			end
			kls_pkg::ST_RESULT: begin
				rd_idx = cnt_q - CW'(1);
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					cnt_d    = '0;
					state_d  = kls_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kls_pkg::ST_IDLE;
			end
		endcase
	end

	kls_ram #(
		.WIDTH (kls_pkg::DATA_W),
		.DEPTH (MAX_K)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx[AW-1:0]),
		.wdata (ram_wdata),
		.raddr (rd_idx[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kls_pkg::ST_IDLE;
			rank_q      <= kls_pkg::RANK_W'(1);
			cnt_q       <= '0;
			k_q         <= CW'(1);
			h_q         <= '0;
			last_q      <= 1'b0;
			short_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			h_q     <= h_d;
			if (cfg_valid && cfg_ready) begin
				rank_q <= rank_k;
			end
			if (accept) begin
				k_q     <= keff;
				last_q  <= last;
				short_q <= (cnt_new < keff);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= value;
		end
		if (load_out) begin
			kth_q       <= $signed(ram_rdata);
			short_out_q <= short_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign kth_value = kth_q;
	assign short_set = short_out_q;

	// writes never land at or beyond the rank in force
	a_wr_in_rank: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (wr_idx < k_q))
		else $error("store write beyond rank");

	// a delivered result empties the store for the next set
	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (cnt_q == '0))
		else $error("count not cleared after result");

	// while an item is in flight the count respects the rank
	a_cnt_le_k: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != kls_pkg::ST_IDLE) |-> ((cnt_q <= k_q) && (k_q != '0)))
		else $error("kept count exceeds rank");

	// a result is only loaded when the output slot is free or draining
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && out_valid_q) |-> out_ready)
		else $error("pending result overwritten");

endmodule
